// File: rtl/core/medt_pkg.sv
`default_nettype none

package medt_pkg;

  // result line index is always this wide, low bits of the line number
  localparam int LINE_INDEX_W = 10;

  // master-side tdata width: line_index, orientation, is_new, table_full, zero fill
  localparam int OUT_DATA_W = 16;

  // control flags of one request on its way from front to back
  typedef struct packed {
    logic clear;
    logic last;
  } medt_ctl_t;

  // one result item
  typedef struct packed {
    logic [LINE_INDEX_W-1:0] line_index;
    logic                    orientation;
    logic                    is_new;
    logic                    table_full;
    logic                    element_done;
  } medt_res_t;

endpackage

`default_nettype wire

// File: rtl/core/medt_front.sv
`default_nettype none

module medt_front #(
  parameter int POINT_BITS = 16,
  parameter int DATA_W     = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [DATA_W-1:0]       s_tdata,
  input  wire logic                    s_tuser,
  input  wire logic                    s_tlast,
  output logic                         f_valid,
  input  wire logic                    f_ready,
  output medt_pkg::medt_ctl_t          f_ctl,
  output logic [2*POINT_BITS-1:0]      f_pts
);

  logic valid;

  assign s_tready = !valid || f_ready;
  assign f_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // classify: a clear request carries no element end
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      f_ctl.clear <= s_tuser;
      f_ctl.last  <= s_tlast & ~s_tuser;
      f_pts       <= s_tdata[2*POINT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/medt_queue.sv
`default_nettype none

module medt_queue #(
  parameter int W = 34
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = slot[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/medt_back.sv
`default_nettype none

module medt_back #(
  parameter int MAX_LINES  = 1024,
  parameter int POINT_BITS = 16,
  parameter int IDX_W      = 10,
  parameter int CNT_W      = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire medt_pkg::medt_ctl_t    q_ctl,
  input  wire logic [2*POINT_BITS-1:0] q_pts,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output medt_pkg::medt_res_t         res,
  output logic [CNT_W-1:0]            line_count
);

  localparam int LW    = medt_pkg::LINE_INDEX_W;
  localparam int EXT_W = (IDX_W > LW) ? IDX_W : LW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MISS = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                  state;
  logic [2*POINT_BITS-1:0] mem [MAX_LINES];
  logic [2*POINT_BITS-1:0] rd_data;
  logic [POINT_BITS-1:0]   cur_a;
  logic [POINT_BITS-1:0]   cur_b;
  logic                    cur_last;
  logic [IDX_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    cmp_ok;
  logic [CNT_W-1:0]        count;
  medt_pkg::medt_res_t     pend;

  logic [POINT_BITS-1:0]   p1;
  logic [POINT_BITS-1:0]   p2;
  logic                    fwd;
  logic                    rev;
  logic [IDX_W-1:0]        last_idx;
  logic                    room;
  logic                    wr_en;
  logic                    emit;
  logic [EXT_W-1:0]        hit_ext;
  logic [EXT_W-1:0]        new_ext;

  assign p1       = rd_data[POINT_BITS-1:0];
  assign p2       = rd_data[2*POINT_BITS-1:POINT_BITS];
  assign fwd      = (p1 == cur_a) && (p2 == cur_b);
  assign rev      = (p2 == cur_a) && (p1 == cur_b);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign room     = (count < CNT_W'(MAX_LINES));
  assign wr_en    = (state == ST_MISS) && room;
  assign emit     = (state == ST_EMIT) && (!res_valid || res_ready);
  assign hit_ext  = EXT_W'(cmp_idx);
  assign new_ext  = EXT_W'(count);

  assign q_ready    = (state == ST_IDLE);
  assign line_count = count;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= {cur_b, cur_a};
    end
    rd_data <= mem[scan_idx];
    cmp_idx <= scan_idx;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_ok    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_a    <= q_pts[POINT_BITS-1:0];
            cur_b    <= q_pts[2*POINT_BITS-1:POINT_BITS];
            cur_last <= q_ctl.last;
            if (q_ctl.clear) begin
              count <= '0;
              pend  <= '0;
              state <= ST_EMIT;
            end else if (count == '0) begin
              state <= ST_MISS;
            end else begin
              scan_idx <= '0;
              cmp_ok   <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_ok <= 1'b1;
          if (scan_idx != last_idx) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
          // same direction wins over reversed, so degenerate edges get 0
          if (cmp_ok && (fwd || rev)) begin
            pend.line_index   <= hit_ext[LW-1:0];
            pend.orientation  <= ~fwd;
            pend.is_new       <= 1'b0;
            pend.table_full   <= 1'b0;
            pend.element_done <= cur_last;
            state             <= ST_EMIT;
          end else if (cmp_ok && (cmp_idx == last_idx)) begin
            state <= ST_MISS;
          end
        end
        ST_MISS: begin
          pend.orientation  <= 1'b0;
          pend.element_done <= cur_last;
          if (room) begin
            pend.line_index <= new_ext[LW-1:0];
            pend.is_new     <= 1'b1;
            pend.table_full <= 1'b0;
            count           <= count + CNT_W'(1);
          end else begin
            pend.line_index <= '0;
            pend.is_new     <= 1'b0;
            pend.table_full <= 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            res   <= pend;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mesh_edge_dedup_table_top.sv
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: from_point, to_point; tuser: kind;
//                                   tlast: element_end
// m_*       out  m_tvalid/m_tready  tdata: line_index, orientation, is_new,
//                                   table_full; tlast: element_done
//
// a clear request goes straight to the result, a lookup on an empty table appends without
// a search, and any other lookup scans the stored lines in order until a hit or the last one:
// the table memory is read one line per cycle
// reset clears control and the line count; the table memory keeps its contents
// and only lines below the count are ever read
// a two-entry request queue lets the input side keep accepting while the
// search runs, and the output register holds a result while the sink stalls
module mesh_edge_dedup_table_top #(
  parameter int MAX_LINES  = 1024,
  parameter int POINT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // from_point, to_point, zero fill to whole bytes
  input  wire logic [((2*POINT_BITS+7)/8)*8-1:0] s_tdata,
  // kind: 0 lookup or insert, 1 clear table
  input  wire logic                           s_tuser,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // line_index, orientation, is_new, table_full, zero fill
  output logic [medt_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  localparam int PT2    = 2 * POINT_BITS;
  localparam int DATA_W = ((PT2 + 7) / 8) * 8;
  localparam int IDX_W  = $clog2(MAX_LINES);
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int Q_W    = PT2 + $bits(medt_pkg::medt_ctl_t);
  localparam int PAD_W  = medt_pkg::OUT_DATA_W - medt_pkg::LINE_INDEX_W - 3;

  // front to queue
  logic                 f_valid;
  logic                 f_ready;
  medt_pkg::medt_ctl_t  f_ctl;
  logic [PT2-1:0]       f_pts;

  // queue to back
  logic                 q_valid;
  logic                 q_ready;
  logic [Q_W-1:0]       q_data;
  medt_pkg::medt_ctl_t  q_ctl;
  logic [PT2-1:0]       q_pts;

  medt_pkg::medt_res_t  res;
  logic [CNT_W-1:0]     line_count;

  assign q_ctl = q_data[Q_W-1:PT2];
  assign q_pts = q_data[PT2-1:0];

  // input register, unpacks and classifies each request
  medt_front #(
    .POINT_BITS (POINT_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_ctl    (f_ctl),
    .f_pts    (f_pts)
  );

  // decouples acceptance from the table search
  medt_queue #(
    .W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_pts}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // line table, linear search and append
  medt_back #(
    .MAX_LINES  (MAX_LINES),
    .POINT_BITS (POINT_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_ctl      (q_ctl),
    .q_pts      (q_pts),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res),
    .line_count (line_count)
  );

  assign m_tdata = {PAD_W'(0), res.table_full, res.is_new, res.orientation, res.line_index};
  assign m_tlast = res.element_done;

  // the line count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= CNT_W'(MAX_LINES))
    else $error("line count above table size");

  // the line count only grows by one line or drops to zero on a clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (line_count != $past(line_count)) |->
      (line_count == '0 || line_count == $past(line_count) + CNT_W'(1)))
    else $error("line count jumped");

  // a result never says both new line and full table
  a_new_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.is_new && res.table_full))
    else $error("result both new and full");

  // a stalled result holds until the sink takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// File: tb/mesh_edge_dedup_table_top_tb.sv
`timescale 1ns / 100ps

module mesh_edge_dedup_table_top_tb;

  localparam int MAX_LINES    = 1024;
  localparam int POINT_BITS   = 16;
  localparam int S_DATA_W     = ((2*POINT_BITS+7)/8)*8;
  localparam int RANDOM_ITEMS = 560;
  localparam int POOL_SIZE    = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT  = 4_000_000;

  // request kinds carried on s_tuser
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam medt_pkg::medt_res_t NO_RES = '0;

  // one row of the directed table; exp is used only where typed is set
  typedef struct packed {
    logic                kind;
    logic [15:0]         from_pt;
    logic [15:0]         to_pt;
    logic                last;
    logic                typed;
    medt_pkg::medt_res_t exp;
  } edge_row_t;

  localparam int DIR_ROWS = 19;

  edge_row_t edge_rows [0:DIR_ROWS-1] = '{
    // degenerate edge stored, then found again with same direction
    '{KIND_EDGE,  16'h0000, 16'h0000, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{KIND_EDGE,  16'h0000, 16'h0000, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    // extreme points, forward then reversed
    '{KIND_EDGE,  16'hFFFF, 16'h0000, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{KIND_EDGE,  16'h0000, 16'hFFFF, 1'b1, 1'b1, '{10'd1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{KIND_EDGE,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'hAAAA, 16'h5555, 1'b1, 1'b0, NO_RES},
    '{KIND_EDGE,  16'h5555, 16'hAAAA, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'hAAAA, 16'h5555, 1'b0, 1'b0, NO_RES},
    // clear zeroes every field, element_done too
    '{KIND_CLEAR, 16'h1234, 16'hABCD, 1'b1, 1'b1, NO_RES},
    '{KIND_EDGE,  16'h5555, 16'hAAAA, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
    // triangle 10 20 30, closing edge first
    '{KIND_EDGE,  16'h001E, 16'h000A, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'h000A, 16'h0014, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'h0014, 16'h001E, 1'b1, 1'b0, NO_RES},
    // neighbor triangle 20 40 30 shares edge 20-30 reversed
    '{KIND_EDGE,  16'h001E, 16'h0014, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'h0014, 16'h0028, 1'b0, 1'b0, NO_RES},
    '{KIND_EDGE,  16'h0028, 16'h001E, 1'b1, 1'b0, NO_RES},
    '{KIND_CLEAR, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, NO_RES},
    '{KIND_CLEAR, 16'h0000, 16'h0000, 1'b1, 1'b1, NO_RES},
    '{KIND_EDGE,  16'h0001, 16'h0002, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b1, 1'b0, 1'b1}}
  };

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [medt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  // shadow of the line table
  logic [15:0] line_from [0:MAX_LINES-1];
  logic [15:0] line_to   [0:MAX_LINES-1];
  int unsigned line_total = 0;

  medt_pkg::medt_res_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int hold_left   = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int requests_sent  = 0;
  int clears_seen    = 0;
  int new_lines      = 0;
  int reversed_hits  = 0;
  int full_hits      = 0;
  int cycle_count    = 0;
  medt_pkg::medt_res_t got_res;
  medt_pkg::medt_res_t want_res;

  mesh_edge_dedup_table_top #(
    .MAX_LINES (MAX_LINES),
    .POINT_BITS(POINT_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // first stored line that matches wins, same direction tested first
  function automatic medt_pkg::medt_res_t resolve_edge(input logic kind,
                                                       input logic [15:0] a,
                                                       input logic [15:0] b,
                                                       input logic last);
    medt_pkg::medt_res_t r;
    int unsigned i;
    r = '0;
    if (kind == KIND_CLEAR) begin
      line_total = 0;
      clears_seen++;
      return r;
    end
    r.element_done = last;
    for (i = 0; i < line_total; i++) begin
      if (line_from[i] == a && line_to[i] == b) begin
        r.line_index = medt_pkg::LINE_INDEX_W'(i);
        return r;
      end
      if (line_to[i] == a && line_from[i] == b) begin
        r.line_index  = medt_pkg::LINE_INDEX_W'(i);
        r.orientation = 1'b1;
        reversed_hits++;
        return r;
      end
    end
    if (line_total < MAX_LINES) begin
      line_from[line_total] = a;
      line_to[line_total]   = b;
      r.line_index = medt_pkg::LINE_INDEX_W'(line_total);
      r.is_new     = 1'b1;
      line_total++;
      new_lines++;
      return r;
    end
    r.table_full = 1'b1;
    full_hits++;
    return r;
  endfunction

  // offer one request, wait for acceptance, then queue what it should give
  task automatic offer_request(input logic kind, input logic [15:0] a, input logic [15:0] b,
                               input logic last, input logic typed,
                               input medt_pkg::medt_res_t typed_res);
    medt_pkg::medt_res_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tlast  <= last;
    s_tdata  <= S_DATA_W'({b, a});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = resolve_edge(kind, a, b, last);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  // sink side: check each accepted result, then pick the next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res = '{m_tdata[9:0], m_tdata[10], m_tdata[11], m_tdata[12], m_tlast};
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
          mismatch_count++;
        end else begin
          want_res = pending_results.pop_front();
          results_seen++;
          if (got_res.line_index !== want_res.line_index) begin
            $error("line_index: expected %0d, got %0d", want_res.line_index,
                   got_res.line_index);
            mismatch_count++;
          end
          if (got_res.orientation !== want_res.orientation) begin
            $error("orientation: expected %b, got %b", want_res.orientation,
                   got_res.orientation);
            mismatch_count++;
          end
          if (got_res.is_new !== want_res.is_new) begin
            $error("is_new: expected %b, got %b", want_res.is_new, got_res.is_new);
            mismatch_count++;
          end
          if (got_res.table_full !== want_res.table_full) begin
            $error("table_full: expected %b, got %b", want_res.table_full,
                   got_res.table_full);
            mismatch_count++;
          end
          if (got_res.element_done !== want_res.element_done) begin
            $error("element_done: expected %b, got %b", want_res.element_done,
                   got_res.element_done);
            mismatch_count++;
          end
        end
      end
      // one long hold-off so the request queue backs up into s_tready
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] pool [0:POOL_SIZE-1];
    logic [15:0] verts [0:5];
    logic [15:0] a;
    logic [15:0] b;
    int rand_items;
    int pick;
    int nv;
    int k;

    rand_items = 0;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = 16'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    send_idle_pct = 26;
    recv_idle_pct = 54;
    for (k = 0; k < DIR_ROWS; k++) begin
      offer_request(edge_rows[k].kind, edge_rows[k].from_pt, edge_rows[k].to_pt,
                    edge_rows[k].last, edge_rows[k].typed, edge_rows[k].exp);
    end

    // random meshes: polygons over a small point pool so edges recur
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 54;
      end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go <= 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 7 || line_total > 160) begin
        offer_request(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, NO_RES);
        for (k = 0; k < POOL_SIZE; k++) pool[k] = 16'($urandom);
        rand_items++;
      end else if (pick < 15) begin
        // stray edge, sometimes degenerate, with a random end mark
        a = 16'($urandom);
        b = ($urandom_range(3) == 0) ? a : 16'($urandom);
        offer_request(KIND_EDGE, a, b, 1'($urandom), 1'b0, NO_RES);
        rand_items++;
      end else begin
        nv = $urandom_range(3, 6);
        for (k = 0; k < nv; k++) verts[k] = pool[$urandom_range(POOL_SIZE-1)];
        offer_request(KIND_EDGE, verts[nv-1], verts[0], 1'b0, 1'b0, NO_RES);
        for (k = 0; k < nv - 1; k++) begin
          offer_request(KIND_EDGE, verts[k], verts[k+1], (k == nv - 2), 1'b0, NO_RES);
        end
        rand_items += nv;
      end
    end

    // after a clear the next edge lands in line 0 again
    send_idle_pct = 0;
    recv_idle_pct = 0;
    offer_request(KIND_CLEAR, 16'h0000, 16'h0000, 1'b1, 1'b1, NO_RES);
    offer_request(KIND_EDGE, 16'h0003, 16'hFFC0, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b1, 1'b0, 1'b1});
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results: %0d clears, %0d new lines, %0d reversed hits,",
             requests_sent, results_seen, clears_seen, new_lines, reversed_hits);
    $display("%0d table-full misses, one sink hold-off of %0d cycles", full_hits,
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
